/* rtl/core/lls_pkg.sv */
// Shared constants, types and fixed-point coefficients of the luma sharpen block.
`default_nettype none

package lls_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Column index, width count (holds MAX_WIDTH itself) and row count (holds MAX_HEIGHT).
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 1);

  // Configuration port.
  localparam int unsigned FW_W      = 12;
  localparam int unsigned FH_W      = 13;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Input commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam int unsigned PIX_W = 8;

  // Gray luminance, Q14.
  localparam int unsigned FRAC_W     = 14;
  localparam int unsigned LUMA_SUM_W = FRAC_W + PIX_W;
  localparam logic [LUMA_SUM_W-1:0] LUMA_KR   = 4899;
  localparam logic [LUMA_SUM_W-1:0] LUMA_KG   = 9617;
  localparam logic [LUMA_SUM_W-1:0] LUMA_KB   = 1868;
  localparam logic [LUMA_SUM_W-1:0] LUMA_HALF = 8192;

  // Mask sum, I and Q in Q14, channel accumulators in Q28.
  localparam int unsigned S_W   = 12;
  localparam int unsigned IQ_W  = 23;
  localparam int unsigned ACC_W = 42;
  localparam int unsigned Q28   = 28;

  localparam logic signed [IQ_W-1:0] K_IR = 9765;
  localparam logic signed [IQ_W-1:0] K_IG = -4489;
  localparam logic signed [IQ_W-1:0] K_IB = -5276;
  localparam logic signed [IQ_W-1:0] K_QR = 3457;
  localparam logic signed [IQ_W-1:0] K_QG = -8569;
  localparam logic signed [IQ_W-1:0] K_QB = 5112;

  localparam logic signed [ACC_W-1:0] K_RI = 15663;
  localparam logic signed [ACC_W-1:0] K_RQ = 10174;
  localparam logic signed [ACC_W-1:0] K_GI = -4456;
  localparam logic signed [ACC_W-1:0] K_GQ = -10600;
  localparam logic signed [ACC_W-1:0] K_BI = -18121;
  localparam logic signed [ACC_W-1:0] K_BQ = 27902;
  localparam logic signed [ACC_W-1:0] HALF_Q28 = ACC_W'(64'd1 << (Q28 - 1));

  typedef struct packed {
    logic [WCNT_W-1:0] w;
    logic [ROW_W-1:0]  h;
  } cfg_t;

  typedef struct packed {
    logic signed [S_W-1:0]  s;
    logic signed [IQ_W-1:0] iq;
    logic signed [IQ_W-1:0] qq;
    logic [PIX_W-1:0]       alpha;
    logic                   frame_last;
  } yiq_t;

endpackage

`default_nettype wire

/* rtl/core/lls_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lls_line_stage.sv */
// Raster counters, line buffers, gray window and mask sum with I/Q terms.
`default_nettype none

module lls_line_stage
  import lls_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             command_i,
  input  wire logic [PIX_W-1:0] in_red_i,
  input  wire logic [PIX_W-1:0] in_green_i,
  input  wire logic [PIX_W-1:0] in_blue_i,
  input  wire logic [PIX_W-1:0] in_alpha_i,
  output logic                  yiq_valid_o,
  input  wire logic             yiq_ready_i,
  output yiq_t                  yiq_o
);

  logic             accept;
  logic             s1_fire;
  logic             last_col;
  logic             last_row;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_next;

  logic             s1_v_q;
  logic             s1_cmd_q;
  logic [PIX_W-1:0] s1_red_q, s1_green_q, s1_blue_q, s1_alpha_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_row0_q;
  logic             s1_lastcol_q;
  logic             s1_flast_q;

  // Write bypass for a read that meets the write of the item ahead.
  logic             hit_old_q, hit_mid_q, hit_rgt_q, hit_pix_q;
  logic [PIX_W-1:0] byp_mid_q, byp_bot_q;
  logic [4*PIX_W-1:0] byp_pix_q;
  logic [PIX_W-1:0] prev_mid_q;

  logic [PIX_W-1:0]   old_rdata, new_rdata, rgt_rdata;
  logic [4*PIX_W-1:0] pix_rdata;
  logic [PIX_W-1:0]   old_rd, new_rd, rgt_rd;
  logic [4*PIX_W-1:0] pix_rd, pix_wr;

  logic [LUMA_SUM_W-1:0] luma_sum;
  logic [PIX_W-1:0]      luma;
  logic [PIX_W-1:0]      top, mid, bot, left, right;
  logic signed [S_W-1:0] top_x, mid_x, bot_x, left_x, right_x, mask_sum;
  logic signed [IQ_W-1:0] pr_x, pg_x, pb_x;

  assign s1_fire     = s1_v_q && (s1_row0_q || yiq_ready_i);
  assign in_ready_o  = !s1_v_q || s1_fire;
  assign accept      = in_valid_i && in_ready_o;
  assign yiq_valid_o = s1_v_q && !s1_row0_q;

  assign last_col = (WCNT_W'(col_q) + WCNT_W'(1)) >= cfg_i.w;
  assign last_row = row_q >= cfg_i.h;
  assign col_next = col_q + COL_W'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      s1_v_q    <= 1'b0;
      hit_old_q <= 1'b0;
      hit_mid_q <= 1'b0;
      hit_rgt_q <= 1'b0;
      hit_pix_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        s1_v_q    <= 1'b1;
        hit_old_q <= s1_fire && (s1_col_q == col_q);
        hit_mid_q <= s1_fire && (s1_col_q == col_q);
        hit_rgt_q <= s1_fire && (s1_col_q == col_next);
        hit_pix_q <= s1_fire && (s1_cmd_q == CMD_PIXEL) && (s1_col_q == col_q);
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q     <= command_i;
      s1_red_q     <= in_red_i;
      s1_green_q   <= in_green_i;
      s1_blue_q    <= in_blue_i;
      s1_alpha_q   <= in_alpha_i;
      s1_col_q     <= col_q;
      s1_row0_q    <= (row_q == '0);
      s1_lastcol_q <= last_col;
      s1_flast_q   <= last_row && last_col;
      byp_mid_q    <= mid;
      byp_bot_q    <= bot;
      byp_pix_q    <= pix_wr;
    end
    if (s1_fire) begin
      prev_mid_q <= mid;
    end
  end

  assign pix_wr = {s1_alpha_q, s1_blue_q, s1_green_q, s1_red_q};

  lls_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_gray_older (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (mid),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (old_rdata)
  );

  lls_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_gray_newer (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (bot),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (new_rdata)
  );

  // Copy of the newer gray line for the right-hand neighbor.
  lls_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_gray_right (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (bot),
    .re_i    (accept),
    .raddr_i (col_next),
    .rdata_o (rgt_rdata)
  );

  lls_ram #(.WIDTH(4 * PIX_W), .DEPTH(MAX_WIDTH)) u_centre_line (
    .clk_i   (clk_i),
    .we_i    (s1_fire && (s1_cmd_q == CMD_PIXEL)),
    .waddr_i (s1_col_q),
    .wdata_i (pix_wr),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (pix_rdata)
  );

  assign old_rd = hit_old_q ? byp_mid_q : old_rdata;
  assign new_rd = hit_mid_q ? byp_bot_q : new_rdata;
  assign rgt_rd = hit_rgt_q ? byp_bot_q : rgt_rdata;
  assign pix_rd = hit_pix_q ? byp_pix_q : pix_rdata;

  assign luma_sum = LUMA_KR * LUMA_SUM_W'(s1_red_q) + LUMA_KG * LUMA_SUM_W'(s1_green_q)
                  + LUMA_KB * LUMA_SUM_W'(s1_blue_q) + LUMA_HALF;
  assign luma     = luma_sum[FRAC_W +: PIX_W];

  // Top row replicates the incoming gray; a drain word repeats the row above.
  always_comb begin
    bot   = (s1_cmd_q == CMD_DRAIN) ? new_rd : luma;
    top   = s1_row0_q ? bot : old_rd;
    mid   = s1_row0_q ? bot : new_rd;
    right = s1_lastcol_q ? mid : rgt_rd;
    left  = (s1_col_q == '0) ? mid : prev_mid_q;
  end

  assign top_x    = $signed(S_W'(top));
  assign mid_x    = $signed(S_W'(mid));
  assign bot_x    = $signed(S_W'(bot));
  assign left_x   = $signed(S_W'(left));
  assign right_x  = $signed(S_W'(right));
  assign mask_sum = (mid_x <<< 2) + mid_x - top_x - bot_x - left_x - right_x;

  assign pr_x = $signed(IQ_W'(pix_rd[0 +: PIX_W]));
  assign pg_x = $signed(IQ_W'(pix_rd[PIX_W +: PIX_W]));
  assign pb_x = $signed(IQ_W'(pix_rd[2*PIX_W +: PIX_W]));

  always_comb begin
    yiq_o.s          = mask_sum;
    yiq_o.iq         = K_IR * pr_x + K_IG * pg_x + K_IB * pb_x;
    yiq_o.qq         = K_QR * pr_x + K_QG * pg_x + K_QB * pb_x;
    yiq_o.alpha      = pix_rd[3*PIX_W +: PIX_W];
    yiq_o.frame_last = s1_flast_q;
  end

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s1_fire |=> s1_v_q && $stable(s1_col_q))
    else $error("stalled word left the line stage");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (col_q == $past(col_q) + COL_W'(1)) || (col_q == '0))
    else $error("column count skipped");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (col_q == '0) || $stable(row_q))
    else $error("row count moved inside a row");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(col_q) && $stable(row_q))
    else $error("raster position moved without a word");

endmodule

`default_nettype wire

/* rtl/core/lls_color_stage.sv */
// YIQ to RGB conversion with rounding, clamping and the output register.
`default_nettype none

module lls_color_stage
  import lls_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             yiq_valid_i,
  output logic                  yiq_ready_o,
  input  wire yiq_t             yiq_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [PIX_W-1:0]      out_red_o,
  output logic [PIX_W-1:0]      out_green_o,
  output logic [PIX_W-1:0]      out_blue_o,
  output logic [PIX_W-1:0]      out_alpha_o,
  output logic                  run_last_o,
  output logic                  frame_last_o
);

  logic s2_v_q;
  yiq_t s2_q;
  logic out_load;
  logic signed [ACC_W-1:0] ys, iq_x, qq_x, r_acc, g_acc, b_acc;

  // Round half up from Q28, then clamp to the channel range.
  function automatic logic [PIX_W-1:0] to_channel(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0]     rnd;
    logic signed [ACC_W-Q28-1:0] whole;
    rnd   = acc + HALF_Q28;
    whole = rnd[ACC_W-1:Q28];
    if (whole < 0) begin
      return '0;
    end else if (whole > 255) begin
      return '1;
    end
    return whole[PIX_W-1:0];
  endfunction

  assign out_load    = s2_v_q && (!out_valid_o || out_ready_i);
  assign yiq_ready_o = !s2_v_q || out_load;
  assign run_last_o  = 1'b1;

  assign ys    = ACC_W'(s2_q.s) <<< Q28;
  assign iq_x  = ACC_W'(s2_q.iq);
  assign qq_x  = ACC_W'(s2_q.qq);
  assign r_acc = ys + K_RI * iq_x + K_RQ * qq_x;
  assign g_acc = ys + K_GI * iq_x + K_GQ * qq_x;
  assign b_acc = ys + K_BI * iq_x + K_BQ * qq_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (yiq_ready_o) begin
        s2_v_q <= yiq_valid_i;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (yiq_ready_o && yiq_valid_i) begin
      s2_q <= yiq_i;
    end
    if (out_load) begin
      out_red_o    <= to_channel(r_acc);
      out_green_o  <= to_channel(g_acc);
      out_blue_o   <= to_channel(b_acc);
      out_alpha_o  <= s2_q.alpha;
      frame_last_o <= s2_q.frame_last;
    end
  end

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !yiq_ready_o |=> s2_v_q && $stable(s2_q))
    else $error("stalled word changed in the color stage");

endmodule

`default_nettype wire

/* rtl/core/luma_laplacian_sharpen_3x3.sv */
// Top level: 3x3 luminance sharpen of an RGBA raster stream.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   pixel   | in_valid_i/in_ready_o, command_i, in_*_i | in
//   result  | out_valid_o/out_ready_i, out_*_o, *_last | out
//   config  | cfg_we_i, cfg_idx_i, cfg_data_i          | in
//
// One word per clock sustained while the output accepts results; after its word is accepted,
// a result passes through the line stage, the color stage and the output register.
// The four line buffers are single-write RAMs with registered reads, so each word's
// reads are issued at its accept edge and a same-cycle write is bypassed.
// Reset clears the raster counters and all valid flags; line buffers are not cleared.
// A stall at the output backs up through both stages; top-row words, which give no
// result, drain through the line stage even while the output is stalled.
`default_nettype none

module luma_laplacian_sharpen_3x3
  import lls_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 command_i,
  input  wire logic [PIX_W-1:0]     in_red_i,
  input  wire logic [PIX_W-1:0]     in_green_i,
  input  wire logic [PIX_W-1:0]     in_blue_i,
  input  wire logic [PIX_W-1:0]     in_alpha_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [PIX_W-1:0]          out_red_o,
  output logic [PIX_W-1:0]          out_green_o,
  output logic [PIX_W-1:0]          out_blue_o,
  output logic [PIX_W-1:0]          out_alpha_o,
  output logic                      run_last_o,
  output logic                      frame_last_o
);

  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  cfg_t            cfg;
  logic            yiq_valid;
  logic            yiq_ready;
  yiq_t            yiq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to the supported frame size.
  always_comb begin
    if (frame_width_q == '0) begin
      cfg.w = WCNT_W'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      cfg.w = WCNT_W'(MAX_WIDTH);
    end else begin
      cfg.w = WCNT_W'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      cfg.h = ROW_W'(1);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      cfg.h = ROW_W'(MAX_HEIGHT);
    end else begin
      cfg.h = ROW_W'(frame_height_q);
    end
  end

  lls_line_stage u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .in_alpha_i  (in_alpha_i),
    .yiq_valid_o (yiq_valid),
    .yiq_ready_i (yiq_ready),
    .yiq_o       (yiq)
  );

  lls_color_stage u_color (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .yiq_valid_i  (yiq_valid),
    .yiq_ready_o  (yiq_ready),
    .yiq_i        (yiq),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .out_alpha_o  (out_alpha_o),
    .run_last_o   (run_last_o),
    .frame_last_o (frame_last_o)
  );

endmodule

`default_nettype wire
